@@ rtl/amseq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// amseq_pkg
// Shared types and constants of the actuator move sequencer.
// ----------------------------------------------------------------------------
package amseq_pkg;

  localparam int unsigned TimeBitsDefault = 16;
  localparam int unsigned CfgAddrBits     = 5;
  localparam int unsigned PhaseBits       = 5;
  localparam int unsigned DispBits        = 16;
  localparam logic [15:0] AlarmDefault    = 16'd500;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_FW_START = 3'd1,
    ACT_BW_START = 3'd2,
    ACT_BW_HOLD  = 3'd3,
    ACT_MAN_STOP = 3'd4,
    ACT_EMG_STOP = 3'd5
  } action_e;

  typedef enum logic [PhaseBits-1:0] {
    PH_IDLE      = 5'd0,
    PH_FW_START  = 5'd1,
    PH_FW_DELAY  = 5'd2,
    PH_FW_ARM    = 5'd3,
    PH_FW_DRIVE  = 5'd4,
    PH_FW_FINISH = 5'd5,
    PH_FW_DONE   = 5'd6,
    PH_BW_START  = 5'd7,
    PH_BW_DELAY  = 5'd8,
    PH_BW_ARM    = 5'd9,
    PH_BW_DRIVE  = 5'd10,
    PH_BW_FINISH = 5'd11,
    PH_BW_DONE   = 5'd12,
    PH_BW_HOLD   = 5'd13,
    PH_MAN_STOP  = 5'd14,
    PH_EMG_STOP  = 5'd15,
    PH_ERR_STOP  = 5'd16
  } phase_e;

  typedef enum logic [2:0] {
    REG_OPTION   = 3'd0,
    REG_FW_DELAY = 3'd1,
    REG_BW_DELAY = 3'd2,
    REG_FW_ALARM = 3'd3,
    REG_BW_ALARM = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic        option_enable;
    logic [15:0] forward_delay;
    logic [15:0] backward_delay;
    logic [15:0] forward_alarm_time;
    logic [15:0] backward_alarm_time;
  } cfg_t;

  typedef struct packed {
    logic                 valve_forward;
    logic                 valve_backward;
    logic                 moving_forward;
    logic                 moving_backward;
    logic                 alarm_not_forward;
    logic                 alarm_not_backward;
    logic [PhaseBits-1:0] phase;
    logic [DispBits-1:0]  elapsed_display;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/amseq_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// amseq_regs
// APB configuration registers: option enable, move delays and alarm times.
// ----------------------------------------------------------------------------
module amseq_regs (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [amseq_pkg::CfgAddrBits-1:0]  paddr,
  input  wire logic [31:0]                        pwdata,
  output logic      [31:0]                        prdata,
  output logic                                    pready,
  output amseq_pkg::cfg_t                         cfg_o
);
  import amseq_pkg::*;

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[CfgAddrBits-1:2]);
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.option_enable       <= 1'b0;
      cfg_q.forward_delay       <= 16'd0;
      cfg_q.backward_delay      <= 16'd0;
      cfg_q.forward_alarm_time  <= AlarmDefault;
      cfg_q.backward_alarm_time <= AlarmDefault;
    end else if (wr_en) begin
      unique case (idx)
        REG_OPTION:   cfg_q.option_enable       <= pwdata[0];
        REG_FW_DELAY: cfg_q.forward_delay       <= pwdata[15:0];
        REG_BW_DELAY: cfg_q.backward_delay      <= pwdata[15:0];
        REG_FW_ALARM: cfg_q.forward_alarm_time  <= pwdata[15:0];
        REG_BW_ALARM: cfg_q.backward_alarm_time <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_OPTION:   prdata = {31'd0, cfg_q.option_enable};
      REG_FW_DELAY: prdata = {16'd0, cfg_q.forward_delay};
      REG_BW_DELAY: prdata = {16'd0, cfg_q.backward_delay};
      REG_FW_ALARM: prdata = {16'd0, cfg_q.forward_alarm_time};
      REG_BW_ALARM: prdata = {16'd0, cfg_q.backward_alarm_time};
      default:      prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/amseq_timer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// amseq_timer
// On-delay timer: counts up to its preset while running, holds 0 when stopped.
// ----------------------------------------------------------------------------
module amseq_timer #(
  parameter int unsigned TIME_BITS = amseq_pkg::TimeBitsDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire logic                 run_i,
  input  wire logic                 load_i,
  input  wire logic [TIME_BITS-1:0] preset_i,
  output logic                      running_o,
  output logic                      done_o,
  output logic      [TIME_BITS-1:0] elapsed_o
);
  import amseq_pkg::*;

  logic                 running_q;
  logic [TIME_BITS-1:0] elapsed_q, elapsed_d;
  logic [TIME_BITS-1:0] preset_q, preset_d;

  assign preset_d = load_i ? preset_i : preset_q;

  always_comb begin
    if (!run_i) begin
      elapsed_d = '0;
    end else if (elapsed_q < preset_d) begin
      elapsed_d = elapsed_q + 1'b1;
    end else begin
      elapsed_d = elapsed_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      elapsed_q <= '0;
      preset_q  <= '0;
    end else if (step_i) begin
      running_q <= run_i;
      elapsed_q <= elapsed_d;
      preset_q  <= preset_d;
    end
  end

  assign running_o = running_q;
  assign done_o    = running_q && (elapsed_q >= preset_q);
  assign elapsed_o = elapsed_q;

endmodule
`default_nettype wire

@@ rtl/amseq_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// amseq_ctrl
// Phase sequencer: command override, phase logic, valve and alarm latches.
// ----------------------------------------------------------------------------
module amseq_ctrl #(
  parameter int unsigned TIME_BITS = amseq_pkg::TimeBitsDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [2:0]        action_i,
  input  wire logic              forward_limit_i,
  input  wire logic              backward_limit_i,
  input  amseq_pkg::cfg_t        cfg_i,
  output amseq_pkg::result_t     result_o
);
  import amseq_pkg::*;

  localparam logic [32:0] TimeMax = (33'd1 << TIME_BITS) - 33'd1;

  phase_e phase_q, phase_d, phase_cmd;
  logic   vb_fw_q, vb_fw_d, vb_bw_q, vb_bw_d;
  logic   mv_fw_q, mv_fw_d, mv_bw_q, mv_bw_d;
  logic   al_fw_q, al_fw_d, al_bw_q, al_bw_d;

  logic                 d_run, d_load, d_running, d_done;
  logic                 l_run, l_load, l_running, l_done;
  logic [TIME_BITS-1:0] d_preset, l_preset, d_elapsed, l_elapsed;
  logic [TIME_BITS-1:0] fw_delay_sat, bw_delay_sat, fw_alarm_sat, bw_alarm_sat;
  logic [15:0]          fw_alarm, bw_alarm;
  logic [TIME_BITS-1:0] disp;
  logic [32:0]          disp_ext;

  function automatic logic [TIME_BITS-1:0] sat_preset(input logic [15:0] v);
    logic [32:0] ext;
    ext = {17'd0, v};
    sat_preset = (ext > TimeMax) ? TimeMax[TIME_BITS-1:0] : ext[TIME_BITS-1:0];
  endfunction

  assign fw_alarm     = (cfg_i.forward_alarm_time != 16'd0) ? cfg_i.forward_alarm_time
                                                             : AlarmDefault;
  assign bw_alarm     = (cfg_i.backward_alarm_time != 16'd0) ? cfg_i.backward_alarm_time
                                                              : AlarmDefault;
  assign fw_delay_sat = sat_preset(cfg_i.forward_delay);
  assign bw_delay_sat = sat_preset(cfg_i.backward_delay);
  assign fw_alarm_sat = sat_preset(fw_alarm);
  assign bw_alarm_sat = sat_preset(bw_alarm);

  // Command overrides the current phase before the phase logic runs
  always_comb begin
    unique case (action_e'(action_i))
      ACT_FW_START: phase_cmd = PH_FW_START;
      ACT_BW_START: phase_cmd = PH_BW_START;
      ACT_BW_HOLD:  phase_cmd = PH_BW_HOLD;
      ACT_MAN_STOP: phase_cmd = PH_MAN_STOP;
      ACT_EMG_STOP: phase_cmd = PH_EMG_STOP;
      default:      phase_cmd = phase_q;
    endcase
  end

  always_comb begin
    phase_d  = phase_cmd;
    vb_fw_d  = vb_fw_q;
    vb_bw_d  = vb_bw_q;
    mv_fw_d  = mv_fw_q;
    mv_bw_d  = mv_bw_q;
    al_fw_d  = al_fw_q;
    al_bw_d  = al_bw_q;
    d_run    = d_running;
    d_load   = 1'b0;
    d_preset = fw_delay_sat;
    l_run    = l_running;
    l_load   = 1'b0;
    l_preset = fw_alarm_sat;
    disp     = '0;

    unique case (phase_cmd)
      PH_IDLE: begin
        {vb_fw_d, vb_bw_d, mv_fw_d, mv_bw_d} = 4'b0000;
        d_run = 1'b0;
      end
      PH_FW_START: begin
        if (cfg_i.option_enable) begin
          d_run    = 1'b1;
          d_load   = 1'b1;
          d_preset = fw_delay_sat;
          phase_d  = PH_FW_DELAY;
        end else begin
          phase_d = PH_FW_DONE;
        end
      end
      PH_FW_DELAY: begin
        disp = d_elapsed;
        if (d_done) begin
          d_run   = 1'b0;
          disp    = '0;
          phase_d = PH_FW_ARM;
        end
      end
      PH_FW_ARM: begin
        l_run    = 1'b1;
        l_load   = 1'b1;
        l_preset = fw_alarm_sat;
        phase_d  = PH_FW_DRIVE;
      end
      PH_FW_DRIVE: begin
        mv_fw_d = 1'b1;
        vb_fw_d = 1'b1;
        mv_bw_d = 1'b0;
        disp    = l_elapsed;
        if (forward_limit_i) begin
          l_run   = 1'b0;
          phase_d = PH_FW_FINISH;
        end
        // alarm wins over a limit on the same tick
        if (l_done) begin
          l_run   = 1'b0;
          al_fw_d = 1'b1;
          phase_d = PH_ERR_STOP;
        end
      end
      PH_FW_FINISH: begin
        d_run   = 1'b0;
        l_run   = 1'b0;
        mv_fw_d = 1'b0;
        vb_fw_d = 1'b0;
        phase_d = PH_FW_DONE;
      end
      PH_FW_DONE: begin
        mv_fw_d = 1'b0;
      end
      PH_BW_START: begin
        if (cfg_i.option_enable) begin
          if (cfg_i.backward_delay != 16'd0) begin
            d_run    = 1'b1;
            d_load   = 1'b1;
            d_preset = bw_delay_sat;
            phase_d  = PH_BW_DELAY;
          end else begin
            phase_d = PH_BW_ARM;
          end
        end else begin
          phase_d = PH_BW_DONE;
        end
      end
      PH_BW_DELAY: begin
        disp = d_elapsed;
        if (d_done) begin
          d_run   = 1'b0;
          disp    = '0;
          phase_d = PH_BW_ARM;
        end
      end
      PH_BW_ARM: begin
        l_run    = 1'b1;
        l_load   = 1'b1;
        l_preset = bw_alarm_sat;
        phase_d  = PH_BW_DRIVE;
      end
      PH_BW_DRIVE: begin
        mv_fw_d = 1'b0;
        vb_fw_d = 1'b0;
        mv_bw_d = 1'b1;
        vb_bw_d = 1'b1;
        // the limit stops the delay timer; the alarm timer stops in finish
        if (backward_limit_i) begin
          mv_bw_d = 1'b0;
          vb_bw_d = 1'b0;
          d_run   = 1'b0;
          phase_d = PH_BW_FINISH;
        end
        disp = l_elapsed;
        if (l_done) begin
          d_run   = 1'b0;
          al_bw_d = 1'b1;
          phase_d = PH_ERR_STOP;
        end
      end
      PH_BW_FINISH: begin
        mv_fw_d = 1'b0;
        mv_bw_d = 1'b0;
        vb_bw_d = 1'b0;
        d_run   = 1'b0;
        l_run   = 1'b0;
        phase_d = PH_BW_DONE;
      end
      PH_BW_DONE: ;
      PH_BW_HOLD: begin
        mv_fw_d = 1'b0;
        mv_bw_d = 1'b1;
        vb_bw_d = 1'b1;
      end
      PH_MAN_STOP, PH_EMG_STOP: begin
        d_run = 1'b0;
        l_run = 1'b0;
        {vb_fw_d, vb_bw_d, mv_fw_d, mv_bw_d} = 4'b0000;
        phase_d = PH_IDLE;
      end
      PH_ERR_STOP: begin
        d_run = 1'b0;
        l_run = 1'b0;
        {vb_fw_d, vb_bw_d, mv_fw_d, mv_bw_d} = 4'b0000;
      end
      default: ;
    endcase
  end

  amseq_timer #(.TIME_BITS(TIME_BITS)) u_delay_timer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step_i),
    .run_i     (d_run),
    .load_i    (d_load),
    .preset_i  (d_preset),
    .running_o (d_running),
    .done_o    (d_done),
    .elapsed_o (d_elapsed)
  );

  amseq_timer #(.TIME_BITS(TIME_BITS)) u_alarm_timer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step_i),
    .run_i     (l_run),
    .load_i    (l_load),
    .preset_i  (l_preset),
    .running_o (l_running),
    .done_o    (l_done),
    .elapsed_o (l_elapsed)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_EMG_STOP;
      vb_fw_q <= 1'b0;
      vb_bw_q <= 1'b0;
      mv_fw_q <= 1'b0;
      mv_bw_q <= 1'b0;
      al_fw_q <= 1'b0;
      al_bw_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      vb_fw_q <= vb_fw_d;
      vb_bw_q <= vb_bw_d;
      mv_fw_q <= mv_fw_d;
      mv_bw_q <= mv_bw_d;
      al_fw_q <= al_fw_d;
      al_bw_q <= al_bw_d;
    end
  end

  assign disp_ext = 33'(disp);

  assign result_o.valve_forward      = vb_fw_d;
  assign result_o.valve_backward     = vb_bw_d;
  assign result_o.moving_forward     = mv_fw_d;
  assign result_o.moving_backward    = mv_bw_d;
  assign result_o.alarm_not_forward  = al_fw_d;
  assign result_o.alarm_not_backward = al_bw_d;
  assign result_o.phase              = phase_d;
  assign result_o.elapsed_display    = disp_ext[DispBits-1:0];

endmodule
`default_nettype wire

@@ rtl/actuator_move_sequencer_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// actuator_move_sequencer_top
// Two-valve actuator move sequencer, one tick per input transfer.
// ----------------------------------------------------------------------------
// From input transfer to result valid, the input register takes the
//   transfer, then one pass of the phase logic goes into the result register.
// Throughput: one item per cycle unless the result side stalls.
// Reset: asynchronous, active low; phase is emergency stop, timers, valves and
//   alarms clear, alarm times are 500 ticks. No clearing pass.
module actuator_move_sequencer_top #(
  parameter int unsigned TIME_BITS = amseq_pkg::TimeBitsDefault
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [amseq_pkg::CfgAddrBits-1:0]  paddr,
  input  wire logic [31:0]                        pwdata,
  output logic      [31:0]                        prdata,
  output logic                                    pready,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [2:0]                         action_i,
  input  wire logic                               forward_limit_i,
  input  wire logic                               backward_limit_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic                                    valve_forward_o,
  output logic                                    valve_backward_o,
  output logic                                    moving_forward_o,
  output logic                                    moving_backward_o,
  output logic                                    alarm_not_forward_o,
  output logic                                    alarm_not_backward_o,
  output logic      [amseq_pkg::PhaseBits-1:0]    phase_o,
  output logic      [amseq_pkg::DispBits-1:0]     elapsed_display_o
);
  import amseq_pkg::*;

  cfg_t    cfg;
  result_t result, result_q;
  logic    in_valid_q, out_valid_q, step;
  logic [2:0] action_q;
  logic       fwl_q, bwl_q;

  amseq_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // advance the held item when the result slot is free or being drained
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      action_q <= action_i;
      fwl_q    <= forward_limit_i;
      bwl_q    <= backward_limit_i;
    end
  end

  amseq_ctrl #(.TIME_BITS(TIME_BITS)) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .action_i         (action_q),
    .forward_limit_i  (fwl_q),
    .backward_limit_i (bwl_q),
    .cfg_i            (cfg),
    .result_o         (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      result_q <= result;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign valve_forward_o      = result_q.valve_forward;
  assign valve_backward_o     = result_q.valve_backward;
  assign moving_forward_o     = result_q.moving_forward;
  assign moving_backward_o    = result_q.moving_backward;
  assign alarm_not_forward_o  = result_q.alarm_not_forward;
  assign alarm_not_backward_o = result_q.alarm_not_backward;
  assign phase_o              = result_q.phase;
  assign elapsed_display_o    = result_q.elapsed_display;

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the actuator move sequencer. Every accepted tick
// is run through a local model of the phase logic and the two on-delay
// timers, and each status word the block returns is checked against it
// field by field. Directed ticks come first. A run that waits out the full
// default alarm window follows, then random move sequences under several
// register settings, with random idle on both channels and one long stall
// of the status side. Register writes are read back over the config port.
// ----------------------------------------------------------------------------
module tb;
  import amseq_pkg::*;

  // bit positions of the drive and indicator outputs
  localparam int unsigned VF = 0;
  localparam int unsigned VB = 1;
  localparam int unsigned MF = 2;
  localparam int unsigned MB = 3;

  localparam int unsigned StallLimit = 5000;
  localparam int unsigned PrintCap   = 200;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [CfgAddrBits-1:0] paddr = '0;
  logic [31:0]            pwdata = '0;
  logic [31:0]            prdata;
  logic                   pready;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [2:0]             action_i = ACT_NONE;
  logic                   forward_limit_i = 1'b0;
  logic                   backward_limit_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic                   valve_forward_o;
  logic                   valve_backward_o;
  logic                   moving_forward_o;
  logic                   moving_backward_o;
  logic                   alarm_not_forward_o;
  logic                   alarm_not_backward_o;
  logic [PhaseBits-1:0]   phase_o;
  logic [DispBits-1:0]    elapsed_display_o;

  actuator_move_sequencer_top u_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .action_i             (action_i),
    .forward_limit_i      (forward_limit_i),
    .backward_limit_i     (backward_limit_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .valve_forward_o      (valve_forward_o),
    .valve_backward_o     (valve_backward_o),
    .moving_forward_o     (moving_forward_o),
    .moving_backward_o    (moving_backward_o),
    .alarm_not_forward_o  (alarm_not_forward_o),
    .alarm_not_backward_o (alarm_not_backward_o),
    .phase_o              (phase_o),
    .elapsed_display_o    (elapsed_display_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // register shadow and sequencer state as they stand after reset
  cfg_t shadow_cfg = '{option_enable: 1'b0, forward_delay: 16'd0,
                       backward_delay: 16'd0, forward_alarm_time: AlarmDefault,
                       backward_alarm_time: AlarmDefault};
  logic [4:0]  sq_phase   = PH_EMG_STOP;
  logic        dly_on     = 1'b0;
  logic [15:0] dly_count  = '0;
  logic [15:0] dly_limit  = '0;
  logic        win_on     = 1'b0;
  logic [15:0] win_count  = '0;
  logic [15:0] win_limit  = '0;
  logic [3:0]  drive_bits = '0;
  logic        alm_fw     = 1'b0;
  logic        alm_bw     = 1'b0;

  result_t     status_due[$];

  int unsigned src_idle_pct  = 29;
  int unsigned sink_idle_pct = 76;
  int unsigned sink_hold     = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned n_mismatch    = 0;
  int unsigned n_ticks_sent  = 0;
  int unsigned n_status_seen = 0;
  int unsigned n_err_ticks   = 0;
  int unsigned n_reg_writes  = 0;

  function automatic logic [15:0] alarm_window(input logic [15:0] t);
    return (t != 16'd0) ? t : AlarmDefault;
  endfunction

  // One tick: command override, one pass of the phase logic on the old
  // timer outputs, then both timers advance.
  function automatic result_t sequencer_tick(input logic [2:0] act, input logic fwl,
                                             input logic bwl);
    result_t     st;
    logic        dly_done;
    logic        win_done;
    logic [15:0] shown;
    shown = '0;
    case (act)
      ACT_FW_START: sq_phase = PH_FW_START;
      ACT_BW_START: sq_phase = PH_BW_START;
      ACT_BW_HOLD:  sq_phase = PH_BW_HOLD;
      ACT_MAN_STOP: sq_phase = PH_MAN_STOP;
      ACT_EMG_STOP: sq_phase = PH_EMG_STOP;
      default: ;
    endcase
    dly_done = dly_on && (dly_count >= dly_limit);
    win_done = win_on && (win_count >= win_limit);
    case (sq_phase)
      PH_IDLE: begin
        drive_bits = '0;
        dly_on = 1'b0;
      end
      PH_FW_START: begin
        if (shadow_cfg.option_enable) begin
          dly_on = 1'b1;
          dly_limit = shadow_cfg.forward_delay;
          sq_phase = PH_FW_DELAY;
        end else begin
          sq_phase = PH_FW_DONE;
        end
      end
      PH_FW_DELAY: begin
        shown = dly_count;
        if (dly_done) begin
          dly_on = 1'b0;
          shown = '0;
          sq_phase = PH_FW_ARM;
        end
      end
      PH_FW_ARM: begin
        win_on = 1'b1;
        win_limit = alarm_window(shadow_cfg.forward_alarm_time);
        sq_phase = PH_FW_DRIVE;
      end
      PH_FW_DRIVE: begin
        drive_bits[MF] = 1'b1;
        drive_bits[VF] = 1'b1;
        drive_bits[MB] = 1'b0;
        shown = win_count;
        if (fwl) begin
          win_on = 1'b0;
          sq_phase = PH_FW_FINISH;
        end
        // alarm beats the limit switch on the same tick
        if (win_done) begin
          win_on = 1'b0;
          alm_fw = 1'b1;
          sq_phase = PH_ERR_STOP;
        end
      end
      PH_FW_FINISH: begin
        dly_on = 1'b0;
        win_on = 1'b0;
        drive_bits[MF] = 1'b0;
        drive_bits[VF] = 1'b0;
        sq_phase = PH_FW_DONE;
      end
      PH_FW_DONE: drive_bits[MF] = 1'b0;
      PH_BW_START: begin
        if (!shadow_cfg.option_enable) begin
          sq_phase = PH_BW_DONE;
        end else if (shadow_cfg.backward_delay != 16'd0) begin
          dly_on = 1'b1;
          dly_limit = shadow_cfg.backward_delay;
          sq_phase = PH_BW_DELAY;
        end else begin
          sq_phase = PH_BW_ARM;
        end
      end
      PH_BW_DELAY: begin
        shown = dly_count;
        if (dly_done) begin
          dly_on = 1'b0;
          shown = '0;
          sq_phase = PH_BW_ARM;
        end
      end
      PH_BW_ARM: begin
        win_on = 1'b1;
        win_limit = alarm_window(shadow_cfg.backward_alarm_time);
        sq_phase = PH_BW_DRIVE;
      end
      PH_BW_DRIVE: begin
        drive_bits[MF] = 1'b0;
        drive_bits[VF] = 1'b0;
        drive_bits[MB] = 1'b1;
        drive_bits[VB] = 1'b1;
        // the backward limit stops the delay timer, not the alarm window
        if (bwl) begin
          drive_bits[MB] = 1'b0;
          drive_bits[VB] = 1'b0;
          dly_on = 1'b0;
          sq_phase = PH_BW_FINISH;
        end
        shown = win_count;
        if (win_done) begin
          dly_on = 1'b0;
          alm_bw = 1'b1;
          sq_phase = PH_ERR_STOP;
        end
      end
      PH_BW_FINISH: begin
        drive_bits[MF] = 1'b0;
        drive_bits[MB] = 1'b0;
        drive_bits[VB] = 1'b0;
        dly_on = 1'b0;
        win_on = 1'b0;
        sq_phase = PH_BW_DONE;
      end
      PH_BW_HOLD: begin
        drive_bits[MF] = 1'b0;
        drive_bits[MB] = 1'b1;
        drive_bits[VB] = 1'b1;
      end
      PH_MAN_STOP, PH_EMG_STOP: begin
        dly_on = 1'b0;
        win_on = 1'b0;
        drive_bits = '0;
        sq_phase = PH_IDLE;
      end
      PH_ERR_STOP: begin
        dly_on = 1'b0;
        win_on = 1'b0;
        drive_bits = '0;
      end
      default: ;
    endcase
    if (!dly_on) dly_count = '0;
    else if (dly_count < dly_limit) dly_count = dly_count + 16'd1;
    if (!win_on) win_count = '0;
    else if (win_count < win_limit) win_count = win_count + 16'd1;
    st.valve_forward      = drive_bits[VF];
    st.valve_backward     = drive_bits[VB];
    st.moving_forward     = drive_bits[MF];
    st.moving_backward    = drive_bits[MB];
    st.alarm_not_forward  = alm_fw;
    st.alarm_not_backward = alm_bw;
    st.phase              = sq_phase;
    st.elapsed_display    = shown;
    return st;
  endfunction

  task automatic log_mismatch(input string msg);
    if (n_mismatch < PrintCap) $display("MISMATCH @%0t: %s", $realtime, msg);
    n_mismatch++;
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want)
      log_mismatch($sformatf("status %0d %s got %0h want %0h", n_status_seen, name,
                             got, want));
  endtask

  // tick capture, status check and stall watchdog
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    logic    moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        status_due.push_back(sequencer_tick(action_i, forward_limit_i, backward_limit_i));
        moved = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        got = {valve_forward_o, valve_backward_o, moving_forward_o, moving_backward_o,
               alarm_not_forward_o, alarm_not_backward_o, phase_o, elapsed_display_o};
        if (status_due.size() == 0) begin
          log_mismatch($sformatf("status word %0h with no tick pending", got));
        end else begin
          want = status_due.pop_front();
          compare_field("valve_forward", 16'(got.valve_forward), 16'(want.valve_forward));
          compare_field("valve_backward", 16'(got.valve_backward),
                        16'(want.valve_backward));
          compare_field("moving_forward", 16'(got.moving_forward),
                        16'(want.moving_forward));
          compare_field("moving_backward", 16'(got.moving_backward),
                        16'(want.moving_backward));
          compare_field("alarm_not_forward", 16'(got.alarm_not_forward),
                        16'(want.alarm_not_forward));
          compare_field("alarm_not_backward", 16'(got.alarm_not_backward),
                        16'(want.alarm_not_backward));
          compare_field("phase", 16'(got.phase), 16'(want.phase));
          compare_field("elapsed_display", got.elapsed_display, want.elapsed_display);
          if (want.phase == PH_ERR_STOP) n_err_ticks++;
        end
        n_status_seen++;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("Watchdog: no transfer for %0d cycles", StallLimit);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // status side: long hold-off on request, else random idle
  always @(posedge clk_i) begin
    if (sink_hold != 0) begin
      sink_hold = sink_hold - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic send_item(input logic [2:0] act, input logic fwl, input logic bwl);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    action_i         <= act;
    forward_limit_i  <= fwl;
    backward_limit_i <= bwl;
    do @(posedge clk_i); while (!in_ready_o);
    n_ticks_sent++;
  endtask

  // drop valid, let every pending status word come back, then settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (status_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_check(input reg_idx_e idx);
    logic [31:0] want;
    logic [31:0] mask;
    case (idx)
      REG_OPTION:   begin want = {31'd0, shadow_cfg.option_enable}; mask = 32'h1; end
      REG_FW_DELAY: begin want = {16'd0, shadow_cfg.forward_delay}; mask = 32'hFFFF; end
      REG_BW_DELAY: begin want = {16'd0, shadow_cfg.backward_delay}; mask = 32'hFFFF; end
      REG_FW_ALARM: begin want = {16'd0, shadow_cfg.forward_alarm_time}; mask = 32'hFFFF; end
      REG_BW_ALARM: begin want = {16'd0, shadow_cfg.backward_alarm_time}; mask = 32'hFFFF; end
      default:      begin want = '0; mask = '0; end
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if ((prdata & mask) !== want)
      log_mismatch($sformatf("register %s read %0h want %0h", idx.name(), prdata & mask,
                             want));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic cfg_write(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_OPTION:   shadow_cfg.option_enable       = value[0];
      REG_FW_DELAY: shadow_cfg.forward_delay       = value[15:0];
      REG_BW_DELAY: shadow_cfg.backward_delay      = value[15:0];
      REG_FW_ALARM: shadow_cfg.forward_alarm_time  = value[15:0];
      REG_BW_ALARM: shadow_cfg.backward_alarm_time = value[15:0];
      default: ;
    endcase
    n_reg_writes++;
    @(posedge clk_i);
    cfg_check(idx);
  endtask

  task automatic load_random_setup();
    cfg_write(REG_OPTION, 32'($urandom_range(9) != 0));
    cfg_write(REG_FW_DELAY, $urandom_range(6));
    cfg_write(REG_BW_DELAY, $urandom_range(6));
    cfg_write(REG_FW_ALARM, $urandom_range(1, 24));
    cfg_write(REG_BW_ALARM, $urandom_range(1, 24));
  endtask

  // Mostly well-formed moves: a command, then plain ticks with the end
  // switch closing at a random point or never. The rest is stop, hold and
  // bursts of random commands.
  task automatic run_moves(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned span;
    int unsigned arrive;
    int unsigned noise_pct;
    logic        fw_move;
    logic        bw_move;
    logic [2:0]  first;
    logic [2:0]  act;
    logic        fl;
    logic        bl;
    stop_at = n_ticks_sent + n_items;
    while (n_ticks_sent < stop_at) begin
      pick = $urandom_range(99);
      fw_move = 1'b0;
      bw_move = 1'b0;
      if (pick < 38) begin
        first = ACT_FW_START;
        fw_move = 1'b1;
      end else if (pick < 76) begin
        first = ACT_BW_START;
        bw_move = 1'b1;
      end else if (pick < 83) first = ACT_BW_HOLD;
      else if (pick < 88) first = ACT_MAN_STOP;
      else if (pick < 92) first = ACT_EMG_STOP;
      else first = 3'($urandom_range(7));
      if (fw_move)
        span = shadow_cfg.forward_delay + alarm_window(shadow_cfg.forward_alarm_time) + 4;
      else if (bw_move)
        span = shadow_cfg.backward_delay + alarm_window(shadow_cfg.backward_alarm_time) + 4;
      else
        span = $urandom_range(1, 10);
      arrive = ($urandom_range(3) == 0) ? span : $urandom_range(span - 1);
      noise_pct = (fw_move || bw_move) ? 5 : 50;
      send_item(first, 1'($urandom_range(1)), 1'($urandom_range(1)));
      for (int unsigned k = 0; k < span; k++) begin
        if (pick >= 92) act = 3'($urandom_range(7));
        else act = ($urandom_range(99) < 4) ? 3'($urandom_range(7)) : ACT_NONE;
        fl = fw_move ? (k >= arrive) : ($urandom_range(99) < noise_pct);
        bl = bw_move ? (k >= arrive) : ($urandom_range(99) < noise_pct);
        send_item(act, fl, bl);
      end
    end
  endtask

  task automatic test_reset_defaults();
    cfg_check(REG_OPTION);
    cfg_check(REG_FW_DELAY);
    cfg_check(REG_BW_DELAY);
    cfg_check(REG_FW_ALARM);
    cfg_check(REG_BW_ALARM);
  endtask

  task automatic test_directed_moves();
    // leaves the emergency stop phase of reset, then unused codes
    send_item(ACT_NONE, 1'b0, 1'b0);
    send_item(3'd6, 1'b1, 1'b1);
    send_item(3'd7, 1'b0, 1'b0);
    // option off: both moves go straight to done
    send_item(ACT_FW_START, 1'b0, 1'b0);
    send_item(ACT_BW_START, 1'b0, 1'b0);
    wait_idle();
    cfg_write(REG_OPTION, 32'd1);
    cfg_write(REG_FW_DELAY, 32'd1);
    cfg_write(REG_BW_DELAY, 32'd0);
    cfg_write(REG_FW_ALARM, 32'd3);
    cfg_write(REG_BW_ALARM, 32'd1);
    // forward move that reaches its limit in time
    send_item(ACT_FW_START, 1'b0, 1'b1);
    repeat (3) send_item(ACT_NONE, 1'b0, 1'b1);
    send_item(ACT_NONE, 1'b1, 1'b0);
    repeat (2) send_item(ACT_NONE, 1'b1, 1'b0);
    // restart while the alarm window runs; it keeps counting into an alarm
    send_item(ACT_FW_START, 1'b0, 1'b0);
    repeat (3) send_item(ACT_NONE, 1'b0, 1'b0);
    send_item(ACT_FW_START, 1'b0, 1'b0);
    repeat (3) send_item(ACT_NONE, 1'b0, 1'b0);
    // hold backward keeps the forward valve as it was
    send_item(ACT_BW_HOLD, 1'b0, 1'b0);
    send_item(ACT_NONE, 1'b0, 1'b0);
    // backward with no delay; limit and alarm on the same tick
    send_item(ACT_BW_START, 1'b0, 1'b0);
    send_item(ACT_NONE, 1'b0, 1'b0);
    send_item(ACT_NONE, 1'b0, 1'b1);
    send_item(ACT_MAN_STOP, 1'b0, 1'b0);
    send_item(ACT_EMG_STOP, 1'b1, 1'b1);
    wait_idle();
  endtask

  // alarm time 0 stands for the default window: forward runs into the
  // alarm, backward reaches its limit well inside the window
  task automatic test_alarm_default_window();
    cfg_write(REG_FW_DELAY, 32'd0);
    cfg_write(REG_FW_ALARM, 32'd0);
    cfg_write(REG_BW_ALARM, 32'd0);
    send_item(ACT_FW_START, 1'b0, 1'b0);
    repeat (AlarmDefault + 6) send_item(ACT_NONE, 1'b0, 1'b0);
    send_item(ACT_BW_START, 1'b0, 1'b0);
    repeat (20) send_item(ACT_NONE, 1'b0, 1'b0);
    repeat (2) send_item(ACT_NONE, 1'b0, 1'b1);
    send_item(ACT_MAN_STOP, 1'b0, 1'b0);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    cfg_write(REG_OPTION, 32'd1);
    cfg_write(REG_FW_DELAY, 32'hFFFF_FFFF);
    cfg_write(REG_BW_DELAY, 32'hFFFF_FFFF);
    cfg_write(REG_FW_ALARM, 32'hFFFF_FFFF);
    cfg_write(REG_BW_ALARM, 32'hFFFF_FFFF);
    // longest delays: abort both while counting
    send_item(ACT_FW_START, 1'b0, 1'b0);
    repeat (10) send_item(ACT_NONE, 1'b0, 1'b0);
    send_item(ACT_MAN_STOP, 1'b0, 1'b0);
    send_item(ACT_BW_START, 1'b0, 1'b0);
    repeat (10) send_item(ACT_NONE, 1'b0, 1'b0);
    send_item(ACT_EMG_STOP, 1'b0, 1'b0);
    send_item(ACT_NONE, 1'b0, 1'b0);
    wait_idle();
    // no delays, longest alarm window: both moves reach their limits
    cfg_write(REG_FW_DELAY, 32'd0);
    cfg_write(REG_BW_DELAY, 32'd0);
    send_item(ACT_FW_START, 1'b0, 1'b1);
    repeat (10) send_item(ACT_NONE, 1'b0, 1'b1);
    repeat (3) send_item(ACT_NONE, 1'b1, 1'b0);
    send_item(ACT_BW_START, 1'b1, 1'b0);
    repeat (10) send_item(ACT_NONE, 1'b1, 1'b0);
    repeat (3) send_item(ACT_NONE, 1'b0, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_moves(input int unsigned src_pct, input int unsigned sink_pct,
                                   input int unsigned n_items);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    load_random_setup();
    run_moves(n_items);
    wait_idle();
  endtask

  // status side holds off while ticks keep coming until the input stalls
  task automatic test_backpressure();
    src_idle_pct = 0;
    load_random_setup();
    sink_hold = 150;
    run_moves(50);
    wait_idle();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed_moves();
    test_alarm_default_window();
    test_random_moves(29, 76, 70);
    test_random_moves(76, 29, 70);
    test_backpressure();
    test_random_moves(0, 0, 70);
    test_register_extremes();
    if (status_due.size() != 0)
      log_mismatch($sformatf("%0d status words never arrived", status_due.size()));
    $display("Covered %0d ticks and %0d status words, %0d of them in error stop.",
             n_ticks_sent, n_status_seen, n_err_ticks);
    $display("Register writes: %0d, each read back; mismatches: %0d.",
             n_reg_writes, n_mismatch);
    if (n_mismatch == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
rtl/amseq_pkg.sv
rtl/amseq_regs.sv
rtl/amseq_timer.sv
rtl/amseq_ctrl.sv
rtl/actuator_move_sequencer_top.sv
tb/tb.sv
